// ===== sv/upt_pkg.sv =====
// shared constants and types for the 64-bit primality tester
package upt_pkg;

  localparam int unsigned NumBases  = 12;
  localparam int unsigned WordW     = 64;
  localparam int unsigned BaseIdxW  = 4;
  localparam int unsigned BitCntW   = 7;

  // small prime bases, also used for trial division
  function automatic logic [5:0] base_val(input logic [BaseIdxW-1:0] idx);
    logic [5:0] v;
    begin
      case (idx)
        4'd0:    v = 6'd2;
        4'd1:    v = 6'd3;
        4'd2:    v = 6'd5;
        4'd3:    v = 6'd7;
        4'd4:    v = 6'd11;
        4'd5:    v = 6'd13;
        4'd6:    v = 6'd17;
        4'd7:    v = 6'd19;
        4'd8:    v = 6'd23;
        4'd9:    v = 6'd29;
        4'd10:   v = 6'd31;
        4'd11:   v = 6'd37;
        default: v = 6'd2;
      endcase
      return v;
    end
  endfunction

  // request to the serial modular multiplier
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } mul_req_t;

  // status back from the serial modular multiplier
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== sv/upt_trial_div.sv =====
// bit-serial remainder of the candidate by one small prime
module upt_trial_div import upt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] n_i,
  input  logic [5:0]       div_i,
  output logic             done_o,
  output logic [5:0]       rem_o
);

  logic [WordW-1:0] sh_q;
  logic [5:0]       rem_q;
  logic [BitCntW-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [6:0]       trial;

  // one quotient bit per cycle, remainder stays below the divisor
  assign trial = {rem_q, sh_q[WordW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == BitCntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= n_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[WordW-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, div_i}) ? 6'(trial - {1'b0, div_i}) : trial[5:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/upt_mod_mul.sv =====
// serial double-and-add modular multiplier, one multiplier bit per cycle
module upt_mod_mul import upt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WordW-1:0] m_i,
  input  mul_req_t         req_i,
  output mul_rsp_t         rsp_o
);

  logic [WordW-1:0] x_q, y_q, acc_q;
  logic             busy_q, done_q;
  logic [WordW:0]   sum, dbl;
  logic [WordW-1:0] acc_n, x_n;

  // operands are already reduced below m
  assign sum   = {1'b0, acc_q} + {1'b0, x_q};
  assign acc_n = (sum >= {1'b0, m_i}) ? WordW'(sum - {1'b0, m_i}) : sum[WordW-1:0];
  assign dbl   = {x_q, 1'b0};
  assign x_n   = (dbl >= {1'b0, m_i}) ? WordW'(dbl - {1'b0, m_i}) : dbl[WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (y_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      acc_q <= '0;
    end else if (busy_q && (y_q != '0)) begin
      if (y_q[0]) acc_q <= acc_n;
      x_q <= x_n;
      y_q <= {1'b0, y_q[WordW-1:1]};
    end
  end

  assign rsp_o = '{done: done_q, prod: acc_q};

endmodule

// ===== sv/u64_primality_test_top.sv =====
// top level: trial division then Miller-Rabin over twelve bases
// Usage: present a 64-bit candidate on n_i with in_valid_i. It transfers
// when in_stall_o is low, which happens only while the block is idle and
// no earlier result is held up by out_stall_i.
// One result, prime_o, leaves on out_valid_o and is held in an output
// register until out_stall_i is low; the next candidate can transfer in
// the same cycle that result transfers.
// Trial division tries each of the twelve small primes in turn, stopping
// early on a match or a zero remainder. Each Miller-Rabin base runs up to
// about 126 serial modular multiplications, each passing through issue,
// one step per multiplier bit, finish and handoff, in the one shared
// multiplier; composites usually exit during trial division or after the
// first base. A new candidate is taken only once the block is idle again.
// Reset clears all control state; no result is pending afterwards.
// A stalled result simply waits; nothing is lost.
module u64_primality_test_top import upt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] n_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             prime_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_TDIV, S_TWAIT, S_CHECK, S_BASE, S_POW_MUL_WAIT, S_POW_STEP,
    S_POW_SQ_WAIT, S_SQ_START, S_SQ_WAIT, S_NEXT, S_DONE
  } state_e;

  state_e           state_q;
  logic [WordW-1:0] n_q, d_q, e_q, a_q, x_q;
  logic [BaseIdxW-1:0] bi_q;
  logic [BitCntW-1:0]  s_q, k_q;
  logic             res_q, ov_q;
  logic             td_start;
  logic             td_done;
  logic [5:0]       td_rem;
  mul_req_t         req;
  mul_rsp_t         rsp;
  logic [WordW-1:0] nm1;
  logic [5:0]       bval;
  logic             take;

  assign nm1  = n_q - 1'b1;
  assign bval = base_val(bi_q);
  assign take = in_valid_i && !in_stall_o;

  assign in_stall_o = (state_q != S_IDLE) || (ov_q && out_stall_i);

  upt_trial_div u_tdiv (
    .clk_i, .rst_ni, .start_i(td_start), .n_i(n_q), .div_i(bval),
    .done_o(td_done), .rem_o(td_rem)
  );

  upt_mod_mul u_mul (
    .clk_i, .rst_ni, .m_i(n_q), .req_i(req), .rsp_o(rsp)
  );

  // sequencer start pulses
  always_comb begin
    td_start  = (state_q == S_TDIV);
    req.start = 1'b0;
    req.x     = x_q;
    req.y     = x_q;
    case (state_q)
      S_BASE: begin
        if (e_q[0]) begin
          req.start = 1'b1;
          req.y     = a_q;
        end
      end
      S_POW_STEP: begin
        if (e_q != '0) begin
          req.start = 1'b1;
          req.x     = a_q;
          req.y     = a_q;
        end
      end
      S_SQ_START: req.start = 1'b1;
      default: req.start = 1'b0;
    endcase
  end

  // main sequencer, exponent bits consumed one per squaring, plus a multiply when the bit is set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      res_q   <= 1'b0;
      bi_q    <= '0;
      n_q     <= '0;
      d_q     <= '0;
      e_q     <= '0;
      a_q     <= '0;
      x_q     <= '0;
      s_q     <= '0;
      k_q     <= '0;
    end else begin
      if (state_q == S_DONE) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            n_q  <= n_i;
            bi_q <= '0;
            if (n_i < WordW'(2)) begin
              res_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_TDIV;
            end
          end
        end
        S_TDIV: state_q <= S_TWAIT;
        S_TWAIT: begin
          if (td_done) begin
            if (n_q == WordW'(bval)) begin
              res_q <= 1'b1;
              state_q <= S_DONE;
            end else if (td_rem == '0) begin
              res_q <= 1'b0;
              state_q <= S_DONE;
            end else if (bi_q == BaseIdxW'(NumBases - 1)) begin
              bi_q <= '0;
              d_q  <= {1'b0, nm1[WordW-1:1]};
              s_q  <= BitCntW'(1);
              state_q <= S_CHECK;
              k_q  <= '1;
            end else begin
              bi_q <= bi_q + 1'b1;
              state_q <= S_TDIV;
            end
          end
        end
        // strip factors of two one per cycle, then set up the power
        S_CHECK: begin
          if (k_q == '1) begin
            if (!d_q[0]) begin
              d_q <= {1'b0, d_q[WordW-1:1]};
              s_q <= s_q + 1'b1;
            end else begin
              k_q <= '0;
            end
          end else begin
            e_q <= d_q;
            a_q <= WordW'(bval);
            x_q <= WordW'(1);
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          if (e_q == '0) begin
            if (x_q == WordW'(1) || x_q == nm1) begin
              state_q <= S_NEXT;
            end else if (s_q <= BitCntW'(1)) begin
              res_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              k_q <= BitCntW'(1);
              state_q <= S_SQ_START;
            end
          end else if (e_q[0]) begin
            state_q <= S_POW_MUL_WAIT;
          end else begin
            state_q <= S_POW_STEP;
          end
        end
        S_POW_MUL_WAIT: begin
          if (rsp.done) begin
            x_q <= rsp.prod;
            state_q <= S_POW_STEP;
          end
        end
        S_POW_STEP: begin
          if (e_q != '0) state_q <= S_POW_SQ_WAIT;
          else state_q <= S_BASE;
        end
        S_POW_SQ_WAIT: begin
          if (rsp.done) begin
            a_q <= rsp.prod;
            e_q <= {1'b0, e_q[WordW-1:1]};
            state_q <= S_BASE;
          end
        end
        // squaring loop, at most s-1 squarings looking for n-1
        S_SQ_START: state_q <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (rsp.done) begin
            x_q <= rsp.prod;
            k_q <= k_q + 1'b1;
            if (rsp.prod == nm1) begin
              state_q <= S_NEXT;
            end else if (BitCntW'(k_q + 1'b1) >= s_q) begin
              res_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SQ_START;
            end
          end
        end
        // base passed, move on or declare prime
        S_NEXT: begin
          if (bi_q == BaseIdxW'(NumBases - 1)) begin
            res_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            bi_q <= bi_q + 1'b1;
            k_q  <= '1;
            d_q  <= {1'b0, nm1[WordW-1:1]};
            s_q  <= BitCntW'(1);
            state_q <= S_CHECK;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign prime_o     = res_q;

endmodule
